// File: rtl/rvalu_pkg.sv
// Shared types and codes for the RV32IM integer execute pipeline.
// Used by rvalu_div, rv32im_integer_alu and its checker; no dependencies.
package rvalu_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned DIV_STEPS = 32;

   localparam logic [2:0] ACT_REG  = 3'd0;
   localparam logic [2:0] ACT_IMM  = 3'd1;
   localparam logic [2:0] ACT_LUI  = 3'd2;
   localparam logic [2:0] ACT_AUIPC = 3'd3;
   localparam logic [2:0] ACT_JALR = 3'd4;

   localparam logic [1:0] F7_BASE   = 2'd0;
   localparam logic [1:0] F7_ALT    = 2'd1;
   localparam logic [1:0] F7_MULDIV = 2'd2;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SRL  = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_MUL    = 3'd0;
   localparam logic [2:0] F3_MULH   = 3'd1;
   localparam logic [2:0] F3_MULHSU = 3'd2;
   localparam logic [2:0] F3_MULHU  = 3'd3;
   localparam logic [2:0] F3_DIV    = 3'd4;
   localparam logic [2:0] F3_DIVU   = 3'd5;
   localparam logic [2:0] F3_REM    = 3'd6;
   localparam logic [2:0] F3_REMU   = 3'd7;

   localparam logic [1:0] SEL_SIMPLE = 2'd0;
   localparam logic [1:0] SEL_MUL    = 2'd1;
   localparam logic [1:0] SEL_DIV    = 2'd2;
   localparam logic [1:0] SEL_REM    = 2'd3;

   localparam logic [XLEN-1:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]      action;
      logic [2:0]      func3;
      logic [1:0]      func7_mode;
      logic [XLEN-1:0] src1;
      logic [XLEN-1:0] src2;
      logic [XLEN-1:0] immediate;
      logic [XLEN-1:0] pc_value;
   } req_type;

   typedef struct packed {
      logic            valid_res;
      logic [XLEN-1:0] result_value;
      logic            jump_taken;
      logic [XLEN-1:0] jump_target;
   } rsp_type;

   // Everything that rides alongside the divider until the final select.
   typedef struct packed {
      logic            valid;
      logic            ok;
      logic [1:0]      sel;
      logic [XLEN-1:0] simple_res;
      logic            jump;
      logic [XLEN-1:0] target;
      logic            div_zero;
      logic            neg_q;
      logic            neg_r;
      logic [XLEN-1:0] src1;
   } side_type;

endpackage

// File: rtl/rvalu_div.sv
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Depends on rvalu_pkg for the word width and the step count.
module rvalu_div (
   input  logic                         clock,
   input  logic [rvalu_pkg::XLEN-1:0]   dividend,
   input  logic [rvalu_pkg::XLEN-1:0]   divisor,
   output logic [rvalu_pkg::XLEN-1:0]   quotient,
   output logic [rvalu_pkg::XLEN-1:0]   remainder
);

   localparam int unsigned W = rvalu_pkg::XLEN;
   localparam int unsigned N = rvalu_pkg::DIV_STEPS;

   logic [W-1:0] rem_ff [N];
   logic [W-1:0] quo_ff [N];
   logic [W-1:0] dvs_ff [N];

   // The quotient register starts out holding the dividend; its top bit is
   // shifted into the partial remainder while a quotient bit enters below.
   function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem_cur,
                                               input logic [W-1:0] quo_cur,
                                               input logic [W-1:0] dvs);
      logic [W:0] shifted;
      logic [W:0] diff;
      begin
         shifted = {rem_cur, quo_cur[W-1]};
         diff    = shifted - {1'b0, dvs};
         if (!diff[W]) begin
            div_step = {diff[W-1:0], quo_cur[W-2:0], 1'b1};
         end else begin
            div_step = {shifted[W-1:0], quo_cur[W-2:0], 1'b0};
         end
      end
   endfunction

   always_ff @(posedge clock) begin
      {rem_ff[0], quo_ff[0]} <= div_step('0, dividend, divisor);
      dvs_ff[0]              <= divisor;
   end

   for (genvar i = 1; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         {rem_ff[i], quo_ff[i]} <= div_step(rem_ff[i-1], quo_ff[i-1], dvs_ff[i-1]);
         dvs_ff[i]              <= dvs_ff[i-1];
      end
   end

   assign quotient  = quo_ff[N-1];
   assign remainder = rem_ff[N-1];

endmodule

// File: rtl/rv32im_integer_alu.sv
// Top level of the RV32IM integer execute pipeline.
// Depends on rvalu_pkg and instantiates rvalu_div.

// One decoded instruction enters per clock whenever start is high; busy is
// always low because nothing stalls the pipeline. Every instruction, simple or
// not, takes the same path: the input register, an operand stage, then 32
// divider stages (one quotient bit each) and an output register. The result
// shows on rsp_data with rsp_strobe high for one cycle, from the output register,
// in issue order. The receiver cannot stall, so it must take every result in the
// cycle it appears.
module rv32im_integer_alu (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  rvalu_pkg::req_type req_data,
   output logic               rsp_strobe,
   output rvalu_pkg::rsp_type rsp_data
);

   localparam int unsigned W = rvalu_pkg::XLEN;
   localparam int unsigned N = rvalu_pkg::DIV_STEPS;

   // Stage A: input register.
   logic               a_valid_ff;
   rvalu_pkg::req_type a_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start;
      end
      a_req_ff <= req_data;
   end

   assign busy = 1'b0;

   // Decode and the simple operations.
   logic [W-1:0]       op2;
   logic [4:0]         shamt;
   logic [W-1:0]       base_res;
   rvalu_pkg::side_type side_in;
   logic               is_signed_div;
   logic               a_neg;
   logic               b_neg;
   logic [W-1:0]       div_a_in;
   logic [W-1:0]       div_b_in;
   logic               mul_a_sgn;
   logic               mul_b_sgn;

   assign op2   = (a_req_ff.action == rvalu_pkg::ACT_REG) ? a_req_ff.src2 : a_req_ff.immediate;
   assign shamt = op2[4:0];

   always_comb begin
      case (a_req_ff.func3)
         rvalu_pkg::F3_ADD:  base_res = a_req_ff.src1 + op2;
         rvalu_pkg::F3_SLL:  base_res = a_req_ff.src1 << shamt;
         rvalu_pkg::F3_SLT:  base_res = {{(W-1){1'b0}}, $signed(a_req_ff.src1) < $signed(op2)};
         rvalu_pkg::F3_SLTU: base_res = {{(W-1){1'b0}}, a_req_ff.src1 < op2};
         rvalu_pkg::F3_XOR:  base_res = a_req_ff.src1 ^ op2;
         rvalu_pkg::F3_SRL:  base_res = a_req_ff.src1 >> shamt;
         rvalu_pkg::F3_OR:   base_res = a_req_ff.src1 | op2;
         default:            base_res = a_req_ff.src1 & op2;
      endcase
   end

   always_comb begin
      side_in            = '0;
      side_in.valid      = a_valid_ff;
      side_in.sel        = rvalu_pkg::SEL_SIMPLE;
      side_in.src1       = a_req_ff.src1;
      side_in.simple_res = base_res;
      unique case (a_req_ff.action)
         rvalu_pkg::ACT_REG: begin
            unique case (a_req_ff.func7_mode)
               rvalu_pkg::F7_BASE: side_in.ok = 1'b1;
               rvalu_pkg::F7_ALT: begin
                  if (a_req_ff.func3 == rvalu_pkg::F3_ADD) begin
                     side_in.ok         = 1'b1;
                     side_in.simple_res = a_req_ff.src1 - a_req_ff.src2;
                  end else if (a_req_ff.func3 == rvalu_pkg::F3_SRL) begin
                     side_in.ok         = 1'b1;
                     side_in.simple_res = W'($signed(a_req_ff.src1) >>> shamt);
                  end
               end
               rvalu_pkg::F7_MULDIV: begin
                  side_in.ok = 1'b1;
                  case (a_req_ff.func3) inside
                     rvalu_pkg::F3_DIV, rvalu_pkg::F3_DIVU: side_in.sel = rvalu_pkg::SEL_DIV;
                     rvalu_pkg::F3_REM, rvalu_pkg::F3_REMU: side_in.sel = rvalu_pkg::SEL_REM;
                     default:                               side_in.sel = rvalu_pkg::SEL_MUL;
                  endcase
               end
               default: side_in.ok = 1'b0;
            endcase
         end
         rvalu_pkg::ACT_IMM: begin
            if (a_req_ff.func3 == rvalu_pkg::F3_SLL) begin
               side_in.ok = (a_req_ff.func7_mode == rvalu_pkg::F7_BASE);
            end else if (a_req_ff.func3 == rvalu_pkg::F3_SRL) begin
               if (a_req_ff.func7_mode == rvalu_pkg::F7_BASE) begin
                  side_in.ok = 1'b1;
               end else if (a_req_ff.func7_mode == rvalu_pkg::F7_ALT) begin
                  side_in.ok         = 1'b1;
                  side_in.simple_res = W'($signed(a_req_ff.src1) >>> shamt);
               end
            end else begin
               side_in.ok = 1'b1;
            end
         end
         rvalu_pkg::ACT_LUI: begin
            side_in.ok         = 1'b1;
            side_in.simple_res = a_req_ff.immediate;
         end
         rvalu_pkg::ACT_AUIPC: begin
            side_in.ok         = 1'b1;
            side_in.simple_res = a_req_ff.immediate + a_req_ff.pc_value;
         end
         rvalu_pkg::ACT_JALR: begin
            if (a_req_ff.func3 == rvalu_pkg::F3_ADD) begin
               side_in.ok         = 1'b1;
               side_in.jump       = 1'b1;
               side_in.simple_res = a_req_ff.pc_value + W'(1);
               side_in.target     = (a_req_ff.src1 + a_req_ff.immediate) & ~W'(1);
            end
         end
         default: side_in.ok = 1'b0;
      endcase
      side_in.div_zero = (a_req_ff.src2 == '0);
      side_in.neg_q    = is_signed_div && (a_neg ^ b_neg);
      side_in.neg_r    = is_signed_div && a_neg;
   end

   // Division runs on magnitudes; signs are restored at the end.
   assign is_signed_div = !a_req_ff.func3[0];
   assign a_neg         = a_req_ff.src1[W-1];
   assign b_neg         = a_req_ff.src2[W-1];
   assign div_a_in      = (is_signed_div && a_neg) ? -a_req_ff.src1 : a_req_ff.src1;
   assign div_b_in      = (is_signed_div && b_neg) ? -a_req_ff.src2 : a_req_ff.src2;

   assign mul_a_sgn = (a_req_ff.func3 == rvalu_pkg::F3_MULH) ||
                      (a_req_ff.func3 == rvalu_pkg::F3_MULHSU);
   assign mul_b_sgn = (a_req_ff.func3 == rvalu_pkg::F3_MULH);

   // Stage B: operand registers and the head of the sideband line.
   rvalu_pkg::side_type side_ff [N+1];
   logic [W-1:0]        div_a_ff;
   logic [W-1:0]        div_b_ff;
   logic signed [W:0]   mul_a_ff;
   logic signed [W:0]   mul_b_ff;
   logic                mul_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].valid <= 1'b0;
      end else begin
         side_ff[0].valid <= side_in.valid;
      end
      side_ff[0].ok         <= side_in.ok;
      side_ff[0].sel        <= side_in.sel;
      side_ff[0].simple_res <= side_in.simple_res;
      side_ff[0].jump       <= side_in.jump;
      side_ff[0].target     <= side_in.target;
      side_ff[0].div_zero   <= side_in.div_zero;
      side_ff[0].neg_q      <= side_in.neg_q;
      side_ff[0].neg_r      <= side_in.neg_r;
      side_ff[0].src1       <= side_in.src1;
      div_a_ff  <= div_a_in;
      div_b_ff  <= div_b_in;
      mul_a_ff  <= $signed({mul_a_sgn & a_req_ff.src1[W-1], a_req_ff.src1});
      mul_b_ff  <= $signed({mul_b_sgn & a_req_ff.src2[W-1], a_req_ff.src2});
      mul_hi_ff <= (a_req_ff.func3 != rvalu_pkg::F3_MUL);
   end

   for (genvar i = 1; i <= N; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i].valid <= 1'b0;
         end else begin
            side_ff[i].valid <= side_ff[i-1].valid;
         end
         side_ff[i].ok         <= side_ff[i-1].ok;
         side_ff[i].sel        <= side_ff[i-1].sel;
         side_ff[i].simple_res <= side_ff[i-1].simple_res;
         side_ff[i].jump       <= side_ff[i-1].jump;
         side_ff[i].target     <= side_ff[i-1].target;
         side_ff[i].div_zero   <= side_ff[i-1].div_zero;
         side_ff[i].neg_q      <= side_ff[i-1].neg_q;
         side_ff[i].neg_r      <= side_ff[i-1].neg_r;
         side_ff[i].src1       <= side_ff[i-1].src1;
      end
   end

   // Multiplier: one product stage, then a delay line to meet the divider.
   logic signed [2*W+1:0] prod_ff;
   logic                  prod_hi_ff;
   logic [W-1:0]          mul_ff [N-1];

   always_ff @(posedge clock) begin
      prod_ff    <= mul_a_ff * mul_b_ff;
      prod_hi_ff <= mul_hi_ff;
      mul_ff[0]  <= prod_hi_ff ? prod_ff[2*W-1:W] : prod_ff[W-1:0];
   end

   for (genvar i = 1; i < N - 1; i++) begin : g_mul
      always_ff @(posedge clock) begin
         mul_ff[i] <= mul_ff[i-1];
      end
   end

   logic [W-1:0] quo;
   logic [W-1:0] rem;

   rvalu_div u_div (
      .clock     (clock),
      .dividend  (div_a_ff),
      .divisor   (div_b_ff),
      .quotient  (quo),
      .remainder (rem)
   );

   // Final select and sign fix-up.
   rvalu_pkg::side_type tail;
   rvalu_pkg::rsp_type  rsp_in;
   rvalu_pkg::rsp_type  rsp_ff;
   logic                rsp_strobe_ff;
   logic [W-1:0]        value;

   assign tail = side_ff[N];

   always_comb begin
      case (tail.sel)
         rvalu_pkg::SEL_MUL: value = mul_ff[N-2];
         rvalu_pkg::SEL_DIV: value = tail.div_zero ? rvalu_pkg::ALL_ONES :
                                     (tail.neg_q ? -quo : quo);
         rvalu_pkg::SEL_REM: value = tail.div_zero ? tail.src1 :
                                     (tail.neg_r ? -rem : rem);
         default:            value = tail.simple_res;
      endcase
      rsp_in = '0;
      if (tail.ok) begin
         rsp_in.valid_res    = 1'b1;
         rsp_in.result_value = value;
         rsp_in.jump_taken   = tail.jump;
         rsp_in.jump_target  = tail.target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= tail.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: rtl/rvalu_chk.sv
// Port-level checker for rv32im_integer_alu, attached with a bind below.
// Depends on rvalu_pkg for the transaction types.
module rvalu_chk (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_strobe,
   input rvalu_pkg::rsp_type rsp_data
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised although the pipeline never stalls");

   a_no_strobe_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.valid_res |->
         rsp_data.result_value == '0 && !rsp_data.jump_taken && rsp_data.jump_target == '0)
      else $error("invalid transaction carries nonzero fields");

   a_target_even: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.jump_taken |-> rsp_data.valid_res && !rsp_data.jump_target[0])
      else $error("jump target odd or jump on invalid transaction");

   a_no_jump_no_target: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.jump_taken |-> rsp_data.jump_target == '0)
      else $error("jump target set without a jump");

endmodule

bind rv32im_integer_alu rvalu_chk u_rvalu_chk (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
